// ===== hw/rtl/baq_pkg.sv =====
package baq_pkg;

  localparam int BLOCK_SIZE = 32;
  localparam int IDX_W      = $clog2(BLOCK_SIZE);

  localparam logic [7:0]  QMAX     = 8'd127;
  localparam logic [31:0] F32_127  = 32'h42FE0000;
  localparam logic [31:0] F32_ONE  = 32'h3F800000;
  localparam logic [31:0] F32_QNAN = 32'h7FC00000;
  localparam logic [30:0] F32_INF_MAG = 31'h7F800000;

  localparam logic REG_EMIT_SUM      = 1'b0;
  localparam logic REG_ROUND_NEAREST = 1'b1;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_MULI = 2'd2;  // b: sign in [31], integer magnitude in [11:0]

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_resp_t;

  function automatic logic [15:0] to_half(input logic [31:0] u);
    logic [15:0]       sgn;
    logic [7:0]        ex;
    logic [23:0]       man;
    logic signed [9:0] e;
    logic [4:0]        shift;
    logic [23:0]       h;
    logic [23:0]       rem;
    logic [23:0]       half;
    logic [15:0]       res;
    sgn   = {u[31], 15'b0};
    ex    = u[30:23];
    man   = {1'b0, u[22:0]};
    e     = $signed({2'b0, ex}) - 10'sd112;
    shift = 5'd0;
    h     = 24'd0;
    rem   = 24'd0;
    half  = 24'd0;
    if (ex == 8'hFF) begin
      res = (man != 24'd0) ? 16'h7E00 : (sgn | 16'h7C00);
    end else if (e >= 10'sd31) begin
      res = sgn | 16'h7C00;
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        res = sgn;
      end else begin
        man   = man | 24'h800000;
        shift = 5'(10'sd14 - e);
        h     = man >> shift;
        rem   = man & ((24'd1 << shift) - 24'd1);
        half  = 24'd1 << (shift - 5'd1);
        if (rem > half || (rem == half && h[0])) h = h + 24'd1;
        res = sgn | h[15:0];
      end
    end else begin
      h   = {9'b0, e[4:0], man[22:13]};
      rem = {11'b0, man[12:0]};
      if (rem > 24'h1000 || (rem == 24'h1000 && h[0])) h = h + 24'd1;
      res = sgn | h[15:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] quantize(input logic [31:0] v, input logic nearest);
    logic [7:0]  ex;
    logic [23:0] m24;
    logic [4:0]  sh;
    logic [23:0] sv;
    logic        fb;
    logic [7:0]  mag;
    ex  = v[30:23];
    m24 = {1'b1, v[22:0]};
    sh  = 5'd0;
    sv  = 24'd0;
    fb  = 1'b0;
    mag = 8'd0;
    if (ex == 8'hFF && v[22:0] != 23'd0) begin
      mag = 8'd0;
    end else if (ex >= 8'd134) begin
      mag = QMAX;
    end else if (ex >= 8'd126) begin
      sh = 5'(8'd150 - ex);
      sv = m24 >> sh;
      fb = m24[sh - 5'd1];
      if (sv >= 24'd127) mag = QMAX;
      else mag = sv[7:0] + {7'b0, nearest & fb};
    end
    return v[31] ? 8'(-mag) : mag;
  endfunction

endpackage

// ===== hw/rtl/baq_fpu.sv =====
module baq_fpu (
  input  logic                clk,
  input  logic                rst,
  input  baq_pkg::fpu_req_t   req,
  output baq_pkg::fpu_resp_t  resp
);

  localparam logic [3:0] F_IDLE     = 4'd0;
  localparam logic [3:0] F_MULT     = 4'd1;
  localparam logic [3:0] F_NORM_A   = 4'd2;
  localparam logic [3:0] F_NORM_B   = 4'd3;
  localparam logic [3:0] F_DIV      = 4'd4;
  localparam logic [3:0] F_DIV_FIN  = 4'd5;
  localparam logic [3:0] F_NORM     = 4'd6;
  localparam logic [3:0] F_DENORM   = 4'd7;
  localparam logic [3:0] F_ROUND    = 4'd8;
  localparam logic [3:0] F_DONE     = 4'd9;

  logic [3:0]         state;
  logic               sgn;
  logic [23:0]        ma, mb;
  logic signed [10:0] ea, eb;
  logic [25:0]        rem;
  logic [25:0]        quo;
  logic [4:0]         cnt;
  logic [47:0]        mant;
  logic               sticky;
  logic signed [10:0] ex;
  logic [31:0]        result;

  // operand unpack: value = m * 2^(e - 150)
  logic [7:0]  a_ex, b_ex;
  logic [23:0] a_m, b_m;
  logic [7:0]  a_e, b_e;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, s_in;

  always_comb begin
    a_ex   = req.a[30:23];
    a_m    = {a_ex != 8'd0, req.a[22:0]};
    a_e    = (a_ex == 8'd0) ? 8'd1 : a_ex;
    a_nan  = (a_ex == 8'hFF) && (req.a[22:0] != 23'd0);
    a_inf  = (a_ex == 8'hFF) && (req.a[22:0] == 23'd0);
    a_zero = (req.a[30:0] == 31'd0);
    b_ex   = req.b[30:23];
    if (req.op == baq_pkg::OP_MULI) begin
      b_m    = {12'b0, req.b[11:0]};
      b_e    = 8'd150;
      b_nan  = 1'b0;
      b_inf  = 1'b0;
      b_zero = (req.b[11:0] == 12'd0);
    end else begin
      b_m    = {b_ex != 8'd0, req.b[22:0]};
      b_e    = (b_ex == 8'd0) ? 8'd1 : b_ex;
      b_nan  = (b_ex == 8'hFF) && (req.b[22:0] != 23'd0);
      b_inf  = (b_ex == 8'hFF) && (req.b[22:0] == 23'd0);
      b_zero = (req.b[30:0] == 31'd0);
    end
    s_in = req.a[31] ^ req.b[31];
  end

  logic        q_bit;
  logic [25:0] q_diff;
  logic [7:0]  r_exf;
  logic [30:0] r_base;
  logic        r_inc;

  always_comb begin
    q_bit  = (rem >= {2'b0, mb});
    q_diff = q_bit ? (rem - {2'b0, mb}) : rem;
    r_exf  = mant[47] ? ex[7:0] : 8'd0;
    r_base = {r_exf, mant[46:24]};
    r_inc  = mant[23] & ((|mant[22:0]) | sticky | mant[24]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.start) begin
            sgn <= s_in;
            ma  <= a_m;
            mb  <= b_m;
            ea  <= $signed({3'b0, a_e});
            eb  <= $signed({3'b0, b_e});
            case (req.op)
              baq_pkg::OP_MUL, baq_pkg::OP_MULI: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                  result <= baq_pkg::F32_QNAN;
                  state  <= F_DONE;
                end else if (a_inf || b_inf) begin
                  result <= {s_in, 8'hFF, 23'b0};
                  state  <= F_DONE;
                end else if (a_zero || b_zero) begin
                  result <= {s_in, 31'b0};
                  state  <= F_DONE;
                end else begin
                  state <= F_MULT;
                end
              end
              baq_pkg::OP_DIV: begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                  result <= baq_pkg::F32_QNAN;
                  state  <= F_DONE;
                end else if (a_inf || b_zero) begin
                  result <= {s_in, 8'hFF, 23'b0};
                  state  <= F_DONE;
                end else if (a_zero || b_inf) begin
                  result <= {s_in, 31'b0};
                  state  <= F_DONE;
                end else begin
                  state <= F_NORM_A;
                end
              end
              default: begin
                result <= baq_pkg::F32_QNAN;
                state  <= F_DONE;
              end
            endcase
          end
        end
        F_MULT: begin
          mant   <= {24'b0, ma} * {24'b0, mb};
          ex     <= ea + eb - 11'sd300;
          sticky <= 1'b0;
          state  <= F_NORM;
        end
        F_NORM_A: begin
          if (!ma[23]) begin
            ma <= {ma[22:0], 1'b0};
            ea <= ea - 11'sd1;
          end else begin
            state <= F_NORM_B;
          end
        end
        F_NORM_B: begin
          if (!mb[23]) begin
            mb <= {mb[22:0], 1'b0};
            eb <= eb - 11'sd1;
          end else begin
            rem   <= {2'b0, ma};
            quo   <= 26'd0;
            cnt   <= 5'd0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= {q_diff[24:0], 1'b0};
          quo <= {quo[24:0], q_bit};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd25) state <= F_DIV_FIN;
        end
        F_DIV_FIN: begin
          mant   <= {22'b0, quo};
          sticky <= (rem != 26'd0);
          ex     <= ea - eb - 11'sd25;
          state  <= F_NORM;
        end
        F_NORM: begin
          if (!mant[47]) begin
            mant <= {mant[46:0], 1'b0};
            ex   <= ex - 11'sd1;
          end else begin
            ex    <= ex + 11'sd174;
            state <= F_DENORM;
          end
        end
        F_DENORM: begin
          if (ex < 11'sd1) begin
            if (ex < -11'sd30) begin
              mant   <= 48'd0;
              sticky <= 1'b1;
              ex     <= 11'sd1;
            end else begin
              mant   <= {1'b0, mant[47:1]};
              sticky <= sticky | mant[0];
              ex     <= ex + 11'sd1;
            end
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (ex >= 11'sd255) result <= {sgn, 8'hFF, 23'b0};
          else result <= {sgn, r_base + {30'b0, r_inc}};
          state <= F_DONE;
        end
        F_DONE: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign resp.done   = (state == F_DONE);
  assign resp.result = result;

endmodule

// ===== hw/rtl/block_absmax_int8_quantizer.sv =====
// Block absmax int8 quantizer.
// Input stream: one single-precision sample per beat on s_axis_tdata. Samples
// are grouped in blocks of 32. After the 32nd beat the block computes
// d = amax / 127, its reciprocal (0 if d is zero or NaN) and 32 int8 values,
// then sends 32 output beats (element 31 carries tlast), each with the value, its
// index, d as a half float and, if emit_sum is set, d times the sum of the values.
// Throughput: one input beat per cycle while a block fills (s_axis_tready
// high), then s_axis_tready stays low until the last output beat is taken.
// Processing after the 32nd beat runs on one shared iterative float unit:
// up to two divisions (amax / 127, then 1 / d), 32 multiplies of a stored
// sample by the reciprocal and, with emit_sum, one more multiply of d by
// the sum of the values; then the output beats are sent one at a time.
// A stalled receiver holds the output beat; the block simply waits.
// Reset (rst, synchronous) empties the current block, drops any pending
// output and clears both configuration registers.
module block_absmax_int8_quantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // quant_value, element_index, scale_half, sum_half
  output logic        m_axis_tlast,   // block_last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_data
);

  localparam logic [3:0] S_FILL     = 4'd0;
  localparam logic [3:0] S_DIV_D    = 4'd1;
  localparam logic [3:0] S_WAIT_D   = 4'd2;
  localparam logic [3:0] S_DIV_ID   = 4'd3;
  localparam logic [3:0] S_WAIT_ID  = 4'd4;
  localparam logic [3:0] S_Q_RD     = 4'd5;
  localparam logic [3:0] S_Q_MUL    = 4'd6;
  localparam logic [3:0] S_Q_WAIT   = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_SUM_WAIT = 4'd9;
  localparam logic [3:0] S_E_RD     = 4'd10;
  localparam logic [3:0] S_E_LD     = 4'd11;
  localparam logic [3:0] S_E_WAIT   = 4'd12;

  localparam logic [baq_pkg::IDX_W-1:0] LAST_IDX = baq_pkg::IDX_W'(baq_pkg::BLOCK_SIZE - 1);

  logic [31:0] mem  [baq_pkg::BLOCK_SIZE];
  logic [7:0]  qmem [baq_pkg::BLOCK_SIZE];

  logic [3:0]                state;
  logic [baq_pkg::IDX_W-1:0] pos;
  logic [baq_pkg::IDX_W-1:0] j;
  logic [30:0]               amax;
  logic [31:0]               d;
  logic [31:0]               id;
  logic signed [12:0]        sumacc;
  logic [15:0]               sumh;
  logic [7:0]                out_q;
  logic                      out_valid;
  logic                      emit_sum;
  logic                      round_nearest;
  logic [31:0]               srd;
  logic [7:0]                qrd;

  baq_pkg::fpu_req_t  fpu_req;
  baq_pkg::fpu_resp_t fpu_resp;

  baq_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (fpu_req),
    .resp (fpu_resp)
  );

  logic        in_beat;
  logic [7:0]  qv;
  logic [12:0] sum_abs;

  always_comb begin
    in_beat = s_axis_tvalid && s_axis_tready;
    qv      = baq_pkg::quantize(fpu_resp.result, round_nearest);
    sum_abs = sumacc[12] ? 13'(-sumacc) : sumacc;
  end

  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = baq_pkg::OP_MUL;
    fpu_req.a     = 32'd0;
    fpu_req.b     = 32'd0;
    case (state)
      S_DIV_D: begin
        fpu_req.start = (amax <= baq_pkg::F32_INF_MAG);
        fpu_req.op    = baq_pkg::OP_DIV;
        fpu_req.a     = {1'b0, amax};
        fpu_req.b     = baq_pkg::F32_127;
      end
      S_DIV_ID: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = baq_pkg::OP_DIV;
        fpu_req.a     = baq_pkg::F32_ONE;
        fpu_req.b     = d;
      end
      S_Q_MUL: begin
        fpu_req.start = 1'b1;
        fpu_req.a     = srd;
        fpu_req.b     = id;
      end
      S_SUM: begin
        fpu_req.start = emit_sum;
        fpu_req.op    = baq_pkg::OP_MULI;
        fpu_req.a     = d;
        fpu_req.b     = {sumacc[12], 19'b0, sum_abs[11:0]};
      end
      default: begin
        fpu_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_beat) mem[pos] <= s_axis_tdata;
    srd <= mem[j];
  end

  always_ff @(posedge clk) begin
    if (state == S_Q_WAIT && fpu_resp.done) qmem[j] <= qv;
    qrd <= qmem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      pos           <= '0;
      j             <= '0;
      amax          <= 31'd0;
      sumacc        <= 13'sd0;
      out_valid     <= 1'b0;
      emit_sum      <= 1'b0;
      round_nearest <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          baq_pkg::REG_EMIT_SUM:      emit_sum      <= cfg_data;
          baq_pkg::REG_ROUND_NEAREST: round_nearest <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_FILL: begin
          if (in_beat) begin
            if (s_axis_tdata[30:0] > amax) amax <= s_axis_tdata[30:0];
            pos <= pos + 1'b1;
            if (pos == LAST_IDX) state <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          j      <= '0;
          sumacc <= 13'sd0;
          if (amax > baq_pkg::F32_INF_MAG) begin
            d     <= baq_pkg::F32_QNAN;
            id    <= 32'd0;
            state <= S_Q_RD;
          end else begin
            state <= S_WAIT_D;
          end
        end
        S_WAIT_D: begin
          if (fpu_resp.done) begin
            d <= fpu_resp.result;
            if (fpu_resp.result[30:0] == 31'd0) begin
              id    <= 32'd0;
              state <= S_Q_RD;
            end else begin
              state <= S_DIV_ID;
            end
          end
        end
        S_DIV_ID: state <= S_WAIT_ID;
        S_WAIT_ID: begin
          if (fpu_resp.done) begin
            id    <= fpu_resp.result;
            state <= S_Q_RD;
          end
        end
        S_Q_RD:  state <= S_Q_MUL;
        S_Q_MUL: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (fpu_resp.done) begin
            sumacc <= sumacc + $signed({{5{qv[7]}}, qv});
            if (j == LAST_IDX) begin
              state <= S_SUM;
            end else begin
              j     <= j + 1'b1;
              state <= S_Q_RD;
            end
          end
        end
        S_SUM: begin
          j <= '0;
          if (emit_sum) begin
            state <= S_SUM_WAIT;
          end else begin
            sumh  <= 16'd0;
            state <= S_E_RD;
          end
        end
        S_SUM_WAIT: begin
          if (fpu_resp.done) begin
            sumh  <= baq_pkg::to_half(fpu_resp.result);
            state <= S_E_RD;
          end
        end
        S_E_RD: state <= S_E_LD;
        S_E_LD: begin
          out_q     <= qrd;
          out_valid <= 1'b1;
          state     <= S_E_WAIT;
        end
        S_E_WAIT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (j == LAST_IDX) begin
              amax  <= 31'd0;
              pos   <= '0;
              state <= S_FILL;
            end else begin
              j     <= j + 1'b1;
              state <= S_E_RD;
            end
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  assign s_axis_tready = (state == S_FILL);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b0, sumh, baq_pkg::to_half(d), j, out_q};
  assign m_axis_tlast  = (j == LAST_IDX);

endmodule

// ===== hw/rtl/baq_checker.sv =====
module baq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while output pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80 && (m_axis_tlast == (m_axis_tdata[12:8] == 5'd31)))
    else $error("bad quant value or tlast");

endmodule

bind block_absmax_int8_quantizer baq_checker u_baq_checker (.*);

// ===== tb/tb_block_absmax_int8_quantizer.sv =====
module tb_block_absmax_int8_quantizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BLOCK_SIZE        = baq_pkg::BLOCK_SIZE;
  localparam logic        REG_EMIT_SUM      = baq_pkg::REG_EMIT_SUM;
  localparam logic        REG_ROUND_NEAREST = baq_pkg::REG_ROUND_NEAREST;

  localparam logic [30:0] INF_MAG    = 31'h7F800000;
  localparam logic [15:0] HALF_QNAN  = 16'h7E00;
  localparam logic [15:0] HALF_INF   = 16'h7C00;
  localparam int          SAT        = 127;

  typedef struct packed {
    logic [7:0]  qval;
    logic [4:0]  idx;
    logic [15:0] scale;
    logic [15:0] sum;
    logic        last;
  } qbeat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // quant_value, element_index, scale_half, sum_half
  logic        m_axis_tlast;   // block_last
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic        cfg_data = 1'b0;

  block_absmax_int8_quantizer i_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] blk_samples [BLOCK_SIZE];
  int          blk_fill;
  logic [30:0] blk_amax;
  logic        sum_en;
  logic        near_en;
  qbeat_t      pending_q[$];

  int src_idle, dst_idle;
  int errors, beats_in, beats_out, blocks_done;

  // real -> single bits, round to nearest even, subnormals and overflow handled
  function automatic logic [31:0] f32_round(real r);
    logic [63:0] b, sig, h, rem, hv, bits;
    int e, sh;
    b = $realtobits(r);
    if (b[62:0] == 0) return {b[63], 31'd0};
    e   = int'(b[62:52]) - 1023;
    sig = {11'd0, 1'b1, b[51:0]};
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    h   = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    hv  = 64'd1 << (sh - 1);
    if (rem > hv || (rem == hv && h[0])) h = h + 64'd1;
    if (e >= -126) begin
      bits = (64'(e + 126) << 23) + h;
      if (bits >= 64'h7F800000) bits = 64'h7F800000;
    end else begin
      bits = h;
    end
    return {b[63], bits[30:0]};
  endfunction

  function automatic real f32_real(logic [31:0] u);
    real v;
    if (u[30:23] == 8'd0)
      v = real'(u[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
    else
      v = $bitstoreal({1'b0, 11'(u[30:23] + 11'd896), u[22:0], 29'd0});
    return u[31] ? -v : v;
  endfunction

  function automatic logic [15:0] half_of(logic [31:0] u);
    int unsigned sgn, ex, man, h, rem, hv, sh;
    int e;
    sgn = u[31] ? 32'h8000 : 0;
    ex  = u[30:23];
    man = u[22:0];
    if (ex == 255) return (man != 0) ? HALF_QNAN : 16'(sgn | HALF_INF);
    e = int'(ex) - 112;
    if (e >= 31) return 16'(sgn | HALF_INF);
    if (e <= 0) begin
      if (e < -10) return 16'(sgn);
      man = man | 32'h800000;
      sh  = 14 - e;
      h   = man >> sh;
      rem = man & ((1 << sh) - 1);
      hv  = 1 << (sh - 1);
      if (rem > hv || (rem == hv && h[0])) h++;
      return 16'(sgn | h);
    end
    h   = (e << 10) | (man >> 13);
    rem = man & 32'h1FFF;
    if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
    return 16'(sgn | h);
  endfunction

  function automatic int to_int8(logic [31:0] p, logic nearest);
    real v, fr;
    int t;
    if (p[30:0] > INF_MAG) return 0;
    if (p[30:0] == INF_MAG) return p[31] ? -SAT : SAT;
    v = f32_real(p);
    if (v >= 127.0) return SAT;
    if (v <= -127.0) return -SAT;
    t = $rtoi(v);
    if (nearest) begin
      fr = v - real'(t);
      if (fr >= 0.5) t++;
      else if (fr <= -0.5) t--;
    end
    return t;
  endfunction

  task automatic quantize_block();
    logic [31:0] dbits, idbits, pbits;
    logic [15:0] scale, sumh;
    int q [BLOCK_SIZE];
    int total;
    qbeat_t bt;
    total = 0;
    for (int j = 0; j < BLOCK_SIZE; j++) q[j] = 0;
    if (blk_amax > INF_MAG) begin
      scale = HALF_QNAN;
      sumh  = sum_en ? HALF_QNAN : 16'h0;
    end else if (blk_amax == INF_MAG) begin
      scale = HALF_INF;
      sumh  = sum_en ? HALF_QNAN : 16'h0;  // inf * 0
    end else begin
      dbits = f32_round(f32_real({1'b0, blk_amax}) / 127.0);
      scale = half_of(dbits);
      if (dbits != 0) begin
        idbits = f32_round(1.0 / f32_real(dbits));
        for (int j = 0; j < BLOCK_SIZE; j++) begin
          if (idbits[30:0] == INF_MAG) begin
            if (blk_samples[j][30:0] == 0) q[j] = 0;
            else q[j] = blk_samples[j][31] ? -SAT : SAT;
          end else begin
            pbits = f32_round(f32_real(blk_samples[j]) * f32_real(idbits));
            q[j]  = to_int8(pbits, near_en);
          end
          total += q[j];
        end
      end
      sumh = sum_en ? half_of(f32_round(f32_real(dbits) * real'(total))) : 16'h0;
    end
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      bt.qval  = 8'(q[j]);
      bt.idx   = 5'(j);
      bt.scale = scale;
      bt.sum   = sumh;
      bt.last  = (j == BLOCK_SIZE - 1);
      pending_q.push_back(bt);
    end
  endtask

  task automatic absorb_sample(logic [31:0] s);
    blk_samples[blk_fill] = s;
    if (s[30:0] > blk_amax) blk_amax = s[30:0];
    if (blk_fill == BLOCK_SIZE - 1) begin
      quantize_block();
      blk_fill = 0;
      blk_amax = '0;
      blocks_done++;
    end else begin
      blk_fill++;
    end
  endtask

  task automatic send_sample(logic [31:0] s);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!s_axis_tready);
    absorb_sample(s);
    beats_in++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic val);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (addr == REG_EMIT_SUM) sum_en = val;
    else near_en = val;
  endtask

  task automatic set_mode(logic sum_on, logic near_on);
    wait_drained();
    write_reg(REG_EMIT_SUM, sum_on);
    write_reg(REG_ROUND_NEAREST, near_on);
  endtask

  function automatic logic [31:0] rand_normal(int ex_base);
    int ex;
    ex = ex_base - $urandom_range(0, 6);
    if (ex < 1) ex = 1;
    return {1'($urandom), 8'(ex), 23'($urandom)};
  endfunction

  // one block of a random flavor
  task automatic send_random_block();
    int kind, spot, base;
    logic [31:0] s;
    kind = $urandom_range(0, 9);
    spot = $urandom_range(0, BLOCK_SIZE - 1);
    base = $urandom_range(90, 160);
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      case (kind)
        0: begin
          s = $urandom;
        end
        1: begin
          s = (j == spot) ? {1'($urandom), 8'hFF, 23'd0} : rand_normal(base);
        end
        2: begin
          s = (j == spot) ? {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))}
                          : rand_normal(base);
        end
        3: begin
          s = {1'($urandom), 8'd0, 23'($urandom_range(0, 255))};
        end
        default: begin
          s = ($urandom_range(15) == 0) ? {1'($urandom), 31'd0} : rand_normal(base);
        end
      endcase
      send_sample(s);
    end
  endtask

  task automatic test_special_blocks();
    logic [31:0] mixed [BLOCK_SIZE];
    mixed = '{32'h00000000, 32'h80000000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
              32'h80000001, 32'h3F800000, 32'hBF800000, 32'h3F000000, 32'hBF000000,
              32'h007FFFFF, 32'h00800000, 32'h4B000000, 32'hCB000000, 32'h7F000000,
              32'h3EFFFFFF, 32'h3F7FFFFF, 32'h40000000, 32'hC0400000, 32'h41200000,
              32'hC1200000, 32'h42FE0000, 32'hC2FE0000, 32'h42FD0000, 32'h3FC00000,
              32'hBFC00000, 32'h40200000, 32'hC0200000, 32'h12345678, 32'h92345678,
              32'h55555555, 32'hAAAAAAAA};
    set_mode(1'b1, 1'b1);
    foreach (mixed[j]) send_sample(mixed[j]);
    wait_drained();
    // infinite amax, then NaN in block
    for (int j = 0; j < BLOCK_SIZE; j++) send_sample(j == 7 ? 32'h7F800000 : rand_normal(130));
    wait_drained();
    for (int j = 0; j < BLOCK_SIZE; j++) send_sample(j == 31 ? 32'hFFC00001 : 32'hFF800000);
    wait_drained();
    // tiny subnormal amax: reciprocal overflows
    for (int j = 0; j < BLOCK_SIZE; j++) send_sample(j[0] ? 32'h0000007F : 32'h80000000 | j);
    wait_drained();
    set_mode(1'b0, 1'b0);
    for (int j = 0; j < BLOCK_SIZE; j++) send_sample(j[0] ? 32'h00000000 : 32'h80000000);
  endtask

  task automatic test_random_mode(logic sum_on, logic near_on, int nblk);
    set_mode(sum_on, near_on);
    repeat (nblk) send_random_block();
  endtask

  always @(posedge clk) begin
    qbeat_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tdata[28:13],
               m_axis_tdata[44:29], m_axis_tlast};
        beats_out++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $realtime, got);
        end else begin
          want = pending_q.pop_front();
          if (got.qval !== want.qval || got.idx !== want.idx || got.scale !== want.scale
              || got.sum !== want.sum || got.last !== want.last) begin
            errors++;
            $display("%0t: exp q=%0d idx=%0d scale=%h sum=%h last=%b", $realtime,
                     $signed(want.qval), want.idx, want.scale, want.sum, want.last);
            $display("%0t: got q=%0d idx=%0d scale=%h sum=%h last=%b", $realtime,
                     $signed(got.qval), got.idx, got.scale, got.sum, got.last);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  initial begin
    errors = 0; beats_in = 0; beats_out = 0; blocks_done = 0;
    blk_fill = 0; blk_amax = '0; sum_en = 1'b0; near_en = 1'b0;
    src_idle = 0; dst_idle = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 14; dst_idle = 78;
    test_random_mode(1'b1, 1'b0, 1);
    src_idle = 78; dst_idle = 14;
    test_random_mode(1'b0, 1'b1, 1);
    src_idle = 0; dst_idle = 0;
    test_special_blocks();
    wait_drained();
    $display("covered %0d samples in %0d blocks, %0d output beats", beats_in,
             blocks_done, beats_out);
    $display("all sum/rounding modes, inf/NaN/subnormal blocks, idle and stall mixes");
    if (errors == 0) begin
      $display("block_absmax_int8_quantizer: match");
    end else begin
      $display("block_absmax_int8_quantizer: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("block_absmax_int8_quantizer: mismatch");
    $finish;
  end

endmodule

// ===== block_absmax_int8_quantizer.f =====
hw/rtl/baq_pkg.sv
hw/rtl/baq_fpu.sv
hw/rtl/block_absmax_int8_quantizer.sv
hw/rtl/baq_checker.sv
tb/tb_block_absmax_int8_quantizer.sv
